// ===== rtl/wsf_pkg.sv =====
`default_nettype none
package wsf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int RING_DEPTH = 2 * MAX_WIDTH + 4;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PEND_W = $clog2(MAX_WIDTH + 3);

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int OUT_W  = 48;
    localparam int WT_W   = 5;
    localparam int SUM_W  = 13;
    localparam int TAP_W  = 4;
    localparam int STEP_W = 3;
    localparam int EXTRA_W = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_EXTRA = 2'd2;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [TAP_W-1:0]  LAST_TAP  = 4'd8;
    localparam logic [STEP_W-1:0] LAST_STEP = 3'd0;
    localparam logic [STEP_W-1:0] FIRST_STEP = 3'd7;

    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_ROWS,
        ST_TAPS,
        ST_LAST,
        ST_DINIT,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              load;
        logic              base;
        logic              rows;
        logic              tap;
        logic [TAP_W-1:0]  tap_idx;
        logic              div_init;
        logic              div_step;
        logic [STEP_W-1:0] step;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic out_free;
    } t_status;

    function automatic logic [1:0] tap_dy(input logic [TAP_W-1:0] k);
        logic [1:0] r;
        if (k < 4'd3) begin
            r = OFS_MINUS;
        end else if (k < 4'd6) begin
            r = OFS_ZERO;
        end else begin
            r = OFS_PLUS;
        end
        return r;
    endfunction

    function automatic logic [1:0] tap_dx(input logic [TAP_W-1:0] k);
        logic [1:0] r;
        case (k) inside
            4'd0, 4'd3, 4'd6: r = OFS_MINUS;
            4'd1, 4'd4, 4'd7: r = OFS_ZERO;
            default:          r = OFS_PLUS;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/wsf_ram.sv =====
`default_nettype none
module wsf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2052,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wsf_ctrl.sv =====
`default_nettype none
module wsf_ctrl
    import wsf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    output logic         o_s_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state            r_state, n_state;
    logic [TAP_W-1:0]  r_tap,   n_tap;
    logic [STEP_W-1:0] r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tap   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid && i_status.go) begin
                    n_state = ST_BASE;
                end
            end
            ST_BASE: n_state = ST_ROWS;
            ST_ROWS: begin
                n_state = ST_TAPS;
                n_tap   = '0;
            end
            ST_TAPS: begin
                n_tap = r_tap + 1'b1;
                if (r_tap == LAST_TAP) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: n_state = ST_DINIT;
            ST_DINIT: begin
                n_state = ST_DIV;
                n_step  = FIRST_STEP;
            end
            ST_DIV: begin
                n_step = r_step - 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_s_ready     = 1'b0;
        o_cmd.tap_idx = r_tap;
        o_cmd.step    = r_step;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            ST_BASE:  o_cmd.base     = 1'b1;
            ST_ROWS:  o_cmd.rows     = 1'b1;
            ST_TAPS:  o_cmd.tap      = 1'b1;
            ST_LAST:  o_cmd.tap      = 1'b0;
            ST_DINIT: o_cmd.div_init = 1'b1;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_EMIT:  o_cmd.emit     = i_status.out_free;
            default:  o_cmd.emit     = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/wsf_dp.sv =====
`default_nettype none
module wsf_dp
    import wsf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [PIX_W-1:0]      i_s_data,
    input  wire logic                  i_s_op,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic                       o_m_valid,
    input  wire logic                  i_m_ready,
    output logic [OUT_W-1:0]           o_m_data,
    output logic                       o_m_last
);

    localparam logic [RING_AW:0] RING_D = (RING_AW + 1)'(RING_DEPTH);

    logic [WID_W-1:0]   r_frame_width;
    logic [HGT_W-1:0]   r_frame_height;
    logic [EXTRA_W-1:0] r_centre_extra;

    logic [COL_W-1:0]   r_in_col, r_out_col;
    logic [ROW_W-1:0]   r_in_row, r_out_row;
    logic [RING_AW-1:0] r_ring_wr;
    logic [PEND_W-1:0]  r_pending;

    logic [RING_AW-1:0] r_base;
    logic [RING_AW-1:0] r_rowb [3];

    logic               r_pend, r_rd_ok;
    logic [WT_W-1:0]    r_rd_wt;
    logic [SUM_W-1:0]   r_sum [3];
    logic [WT_W-1:0]    r_wsum;
    logic [SUM_W-1:0]   r_rem [3];
    logic [WT_W-1:0]    r_den;
    logic [CH_W-1:0]    r_quo [3];

    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic               r_out_last;

    logic [WID_W-1:0]   w;
    logic [HGT_W-1:0]   h;
    logic [PEND_W-1:0]  pend_inc;
    logic               push;
    logic               col_wrap, row_wrap, ocol_wrap, orow_wrap;
    logic [RING_AW:0]   base_sum, rowm_sum, rowp_sum;
    logic [1:0]         dy, dx;
    logic [RING_AW-1:0] rb, rd_addr;
    logic               x_ok, y_ok;
    logic [WT_W-1:0]    wt;
    logic [PIX_W-1:0]   rd_data;
    logic [SUM_W-1:0]   den_sh;
    logic               out_free;

    always_comb begin
        if (r_frame_width == '0) begin
            w = WID_W'(1);
        end else if (r_frame_width > WID_W'(MAX_WIDTH)) begin
            w = WID_W'(MAX_WIDTH);
        end else begin
            w = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h = HGT_W'(1);
        end else if (r_frame_height > HGT_W'(MAX_HEIGHT)) begin
            h = HGT_W'(MAX_HEIGHT);
        end else begin
            h = r_frame_height;
        end
    end

    assign push     = (i_s_op == OP_PUSH);
    assign pend_inc = r_pending + 1'b1;
    assign col_wrap = ({1'b0, r_in_col} + WID_W'(1)) >= w;
    assign row_wrap = ({1'b0, r_in_row} + HGT_W'(1)) >= h;
    assign ocol_wrap = ({1'b0, r_out_col} + WID_W'(1)) >= w;
    assign orow_wrap = ({1'b0, r_out_row} + HGT_W'(1)) >= h;
    assign out_free = !r_out_valid || i_m_ready;

    always_comb begin
        o_status.out_free = out_free;
        if (push) begin
            o_status.go = ({1'b0, pend_inc} > ({1'b0, w} + (WID_W + 1)'(1)));
        end else begin
            o_status.go = (r_in_col == '0) && (r_in_row == '0) && (r_pending != '0);
        end
    end

    always_comb begin
        if ({1'b0, r_ring_wr} >= (RING_AW + 1)'(r_pending)) begin
            base_sum = {1'b0, r_ring_wr} - (RING_AW + 1)'(r_pending);
        end else begin
            base_sum = {1'b0, r_ring_wr} + RING_D - (RING_AW + 1)'(r_pending);
        end
        if ({1'b0, r_base} >= (RING_AW + 1)'(w)) begin
            rowm_sum = {1'b0, r_base} - (RING_AW + 1)'(w);
        end else begin
            rowm_sum = {1'b0, r_base} + RING_D - (RING_AW + 1)'(w);
        end
        rowp_sum = {1'b0, r_base} + (RING_AW + 1)'(w);
        if (rowp_sum >= RING_D) begin
            rowp_sum = rowp_sum - RING_D;
        end
    end

    always_comb begin
        dy = tap_dy(i_cmd.tap_idx);
        dx = tap_dx(i_cmd.tap_idx);
        rb = r_rowb[dy];
        case (dx)
            OFS_MINUS: rd_addr = (rb == '0) ? RING_AW'(RING_DEPTH - 1) : rb - 1'b1;
            OFS_PLUS:  rd_addr = (rb == RING_AW'(RING_DEPTH - 1)) ? '0 : rb + 1'b1;
            default:   rd_addr = rb;
        endcase
        case (dx)
            OFS_MINUS: x_ok = (r_out_col != '0);
            OFS_PLUS:  x_ok = !ocol_wrap;
            default:   x_ok = 1'b1;
        endcase
        case (dy)
            OFS_MINUS: y_ok = (r_out_row != '0);
            OFS_PLUS:  y_ok = !orow_wrap;
            default:   y_ok = 1'b1;
        endcase
        wt = WT_W'(3) - WT_W'(dx != OFS_ZERO) - WT_W'(dy != OFS_ZERO);
        if ((dx == OFS_ZERO) && (dy == OFS_ZERO)) begin
            wt = wt + WT_W'(r_centre_extra);
        end
        den_sh = SUM_W'(r_den) << i_cmd.step;
    end

    wsf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RING_DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load && push),
        .i_wr_addr (r_ring_wr),
        .i_wr_data (i_s_data),
        .i_rd_en   (i_cmd.tap),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WID_W'(640);
            r_frame_height <= HGT_W'(480);
            r_centre_extra <= EXTRA_W'(5);
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_ring_wr      <= '0;
            r_pending      <= '0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_pend <= i_cmd.tap;
            if (i_cmd.load && push) begin
                r_ring_wr <= (r_ring_wr == RING_AW'(RING_DEPTH - 1)) ? '0 : r_ring_wr + 1'b1;
                r_pending <= pend_inc;
                if (col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= row_wrap ? '0 : r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_pending <= r_pending - 1'b1;
                if (ocol_wrap) begin
                    r_out_col <= '0;
                    r_out_row <= orow_wrap ? '0 : r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr) begin
                unique case (i_cfg_index)
                    REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
                        if (i_cfg_index == REG_FRAME_WIDTH) begin
                            r_frame_width <= i_cfg_data[WID_W-1:0];
                        end else begin
                            r_frame_height <= i_cfg_data[HGT_W-1:0];
                        end
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                        r_ring_wr <= '0;
                        r_pending <= '0;
                    end
                    REG_CENTRE_EXTRA: r_centre_extra <= i_cfg_data[EXTRA_W-1:0];
                    default: r_centre_extra <= r_centre_extra;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.base) begin
            r_base <= base_sum[RING_AW-1:0];
        end
        if (i_cmd.rows) begin
            r_rowb[0] <= rowm_sum[RING_AW-1:0];
            r_rowb[1] <= r_base;
            r_rowb[2] <= rowp_sum[RING_AW-1:0];
            r_sum[0]  <= '0;
            r_sum[1]  <= '0;
            r_sum[2]  <= '0;
            r_wsum    <= '0;
        end
        if (i_cmd.tap) begin
            r_rd_ok <= x_ok && y_ok;
            r_rd_wt <= wt;
        end
        if (r_pend && r_rd_ok) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(rd_data[c*CH_W +: CH_W]) * SUM_W'(r_rd_wt);
            end
            r_wsum <= r_wsum + r_rd_wt;
        end
        if (i_cmd.div_init) begin
            r_den <= (r_wsum == '0) ? WT_W'(1) : r_wsum;
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= r_sum[c];
                r_quo[c] <= '0;
            end
        end
        if (i_cmd.div_step) begin
            for (int c = 0; c < 3; c++) begin
                if (r_rem[c] >= den_sh) begin
                    r_rem[c]              <= r_rem[c] - den_sh;
                    r_quo[c][i_cmd.step]  <= 1'b1;
                end
            end
        end
        if (i_cmd.emit) begin
            r_out_data <= {2'b00, r_out_row, r_out_col, r_quo[2], r_quo[1], r_quo[0]};
            r_out_last <= ocol_wrap && orow_wrap;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {2'b00, r_out_data[OUT_W-3:0]};
    assign o_m_last  = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/weighted_3x3_smoothing_filter_core.sv =====
// A word that yields a result passes through the base and row set-up, nine line-store
// reads through one read port, then an 8-step divider, before it is shown on m_axis; no new
// word is taken until that result is emitted. A word that yields none needs none of these steps.
// Reset: i_rst_n is synchronous, active low; clears control, counters and the output
// register and loads 640/480/5 into the registers; the line store is not cleared.
`default_nettype none
module weighted_3x3_smoothing_filter_core
    import wsf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [PIX_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue
    input  wire logic [0:0]            s_axis_tuser,  // operation
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_W-1:0]           m_axis_tdata,  // out_red, out_green, out_blue,
                                                      // out_column, out_row, zero pad
    output logic                       m_axis_tlast
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    wsf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    wsf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_data    (s_axis_tdata),
        .i_s_op      (s_axis_tuser[0]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_axis_tdata),
        .o_m_last    (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/wsf_checker.sv =====
`default_nettype none
module wsf_checker
    import wsf_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [PIX_W-1:0]      s_axis_tdata,
    input wire logic [0:0]            s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_W-1:0]      m_axis_tdata,
    input wire logic                  m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:OUT_W-2] == 2'b00)
        else $error("output padding not zero");

    a_no_accept_before_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("input taken while a result was being computed");

    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("input not ready once a result is shown");

endmodule

bind weighted_3x3_smoothing_filter_core wsf_checker u_wsf_checker (.*);
`default_nettype wire

// ===== tb/smoothing_checker.sv =====
`default_nettype none
module smoothing_checker
    import wsf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [PIX_W-1:0]      i_in_data,
    input  wire logic [0:0]            i_in_user,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [OUT_W-1:0]      i_out_data,
    input  wire logic                  i_out_last,
    output int                         o_errors,
    output int                         o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             frame_done;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
    } t_smoothed;

    logic [PIX_W-1:0] line_ring [RING_DEPTH];
    logic [10:0]      frame_w;
    logic [12:0]      frame_h;
    logic [3:0]       centre_extra;
    int unsigned      ring_wr, pend, in_col, in_row, out_col, out_row;
    t_smoothed        smoothed_q[$];

    assign o_waiting = smoothed_q.size();

    function automatic int unsigned width_used();
        if (frame_w == 0) return 1;
        if (frame_w > MAX_WIDTH) return MAX_WIDTH;
        return frame_w;
    endfunction

    function automatic int unsigned height_used();
        if (frame_h == 0) return 1;
        if (frame_h > MAX_HEIGHT) return MAX_HEIGHT;
        return frame_h;
    endfunction

    task automatic restart_positions();
        ring_wr = 0; pend = 0;
        in_col = 0; in_row = 0;
        out_col = 0; out_row = 0;
    endtask

    task automatic queue_smoothed();
        int unsigned w, h, base, wsum, wt, sr, sg, sb, idx;
        int          x, y;
        t_smoothed   res;
        w = width_used();
        h = height_used();
        base = (ring_wr + RING_DEPTH - pend) % RING_DEPTH;
        wsum = 0; sr = 0; sg = 0; sb = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                x = int'(out_col) + dx;
                y = int'(out_row) + dy;
                if (x >= 0 && x < int'(w) && y >= 0 && y < int'(h)) begin
                    idx = (int'(base) + RING_DEPTH + dy * int'(w) + dx) % RING_DEPTH;
                    wt = 3 - (dx < 0 ? -dx : dx) - (dy < 0 ? -dy : dy);
                    if (dx == 0 && dy == 0) wt += centre_extra;
                    sr += line_ring[idx][7:0] * wt;
                    sg += line_ring[idx][15:8] * wt;
                    sb += line_ring[idx][23:16] * wt;
                    wsum += wt;
                end
            end
        end
        if (wsum == 0) wsum = 1;
        res.red = CH_W'(sr / wsum);
        res.green = CH_W'(sg / wsum);
        res.blue = CH_W'(sb / wsum);
        res.col = COL_W'(out_col);
        res.row = ROW_W'(out_row);
        res.frame_done = 1'b0;
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) begin
                out_row = 0;
                res.frame_done = 1'b1;
            end
        end
        pend--;
        smoothed_q.push_back(res);
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_smoothed exp_res;
        t_smoothed got_res;
        if (!i_rst_n) begin
            frame_w = 11'd640;
            frame_h = 13'd480;
            centre_extra = 4'd5;
            restart_positions();
            smoothed_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got_res = {i_out_last, i_out_data[45:0]};
                if (smoothed_q.size() == 0) begin
                    report("unexpected word", 64'(i_out_data), 64'(0));
                end else begin
                    exp_res = smoothed_q.pop_front();
                    if (got_res.red != exp_res.red) report("red", got_res.red, exp_res.red);
                    if (got_res.green != exp_res.green)
                        report("green", got_res.green, exp_res.green);
                    if (got_res.blue != exp_res.blue) report("blue", got_res.blue, exp_res.blue);
                    if (got_res.col != exp_res.col) report("column", got_res.col, exp_res.col);
                    if (got_res.row != exp_res.row) report("row", got_res.row, exp_res.row);
                    if (got_res.frame_done != exp_res.frame_done)
                        report("tlast", got_res.frame_done, exp_res.frame_done);
                    if (i_out_data[OUT_W-1:46] != '0) report("pad", i_out_data[OUT_W-1:46], 0);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH: begin
                        frame_w = i_cfg_data[10:0];
                        restart_positions();
                    end
                    REG_FRAME_HEIGHT: begin
                        frame_h = i_cfg_data[12:0];
                        restart_positions();
                    end
                    REG_CENTRE_EXTRA: centre_extra = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user[0] == OP_PUSH) begin
                    line_ring[ring_wr] = i_in_data;
                    ring_wr = (ring_wr + 1) % RING_DEPTH;
                    pend++;
                    in_col++;
                    if (in_col >= width_used()) begin
                        in_col = 0;
                        in_row++;
                        if (in_row >= height_used()) in_row = 0;
                    end
                    if (pend > width_used() + 1) queue_smoothed();
                end else if (in_col == 0 && in_row == 0 && pend > 0) begin
                    queue_smoothed();
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_weighted_3x3_smoothing_filter_core.sv =====
`default_nettype none
module tb_weighted_3x3_smoothing_filter_core;
    import wsf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE = 30;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  px_valid;
    logic                  px_ready;
    logic [PIX_W-1:0]      px_data;
    logic [0:0]            px_op;
    logic                  sm_valid;
    logic                  sm_ready;
    logic [OUT_W-1:0]      sm_data;
    logic                  sm_last;
    int                    chk_errors;
    int                    chk_waiting;
    int                    cycles;
    int                    words_sent;
    int                    stall_left;
    bit                    calm;

    weighted_3x3_smoothing_filter_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .s_axis_tvalid(px_valid), .s_axis_tready(px_ready),
        .s_axis_tdata(px_data), .s_axis_tuser(px_op),
        .m_axis_tvalid(sm_valid), .m_axis_tready(sm_ready),
        .m_axis_tdata(sm_data), .m_axis_tlast(sm_last)
    );

    smoothing_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(px_valid), .i_in_ready(px_ready),
        .i_in_data(px_data), .i_in_user(px_op),
        .i_out_valid(sm_valid), .i_out_ready(sm_ready),
        .i_out_data(sm_data), .i_out_last(sm_last),
        .o_errors(chk_errors), .o_waiting(chk_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_weighted_3x3_smoothing_filter_core: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            sm_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            sm_ready <= 1'b0;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(0, 3);
        end else begin
            sm_ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        p = PIX_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            for (int c = 0; c < 3; c++) p[c*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    task automatic send_word(input logic op, input logic [PIX_W-1:0] px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            px_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        px_valid <= 1'b1;
        px_op <= op;
        px_data <= px;
        do @(posedge i_clk); while (!px_ready);
        words_sent++;
    endtask

    task automatic wait_drained();
        px_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_waiting != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int extra);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CENTRE_EXTRA, extra);
    endtask

    task automatic push_pixels(input int n);
        for (int i = 0; i < n; i++) send_word(OP_PUSH, rand_pixel());
    endtask

    task automatic drain(input int n);
        for (int i = 0; i < n; i++) send_word(OP_DRAIN, rand_pixel());
    endtask

    initial begin
        int w, h, frames;
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        px_valid = 1'b0;
        px_data = '0;
        px_op = OP_PUSH;
        sm_ready = 1'b0;
        stall_left = 0;
        cycles = 0;
        words_sent = 0;
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing pending, then a tiny frame with extreme pixels
        drain(1);
        set_geometry(3, 2, 0);
        send_word(OP_PUSH, 24'h000000);
        send_word(OP_PUSH, 24'hFFFFFF);
        send_word(OP_PUSH, 24'hFF00FF);
        send_word(OP_DRAIN, 24'h0);
        send_word(OP_PUSH, 24'h00FF00);
        send_word(OP_PUSH, 24'hFFFFFF);
        send_word(OP_PUSH, 24'h000000);
        drain(5);
        set_geometry(0, 0, 15);
        write_reg(REG_SPARE, 13'h1FFF);
        push_pixels(2);
        drain(2);
        // geometry write drops what is still pending
        set_geometry(4, 3, 7);
        push_pixels(12);
        drain(2);
        set_geometry(4, 3, 9);
        push_pixels(12);
        wait_drained();
        write_reg(REG_CENTRE_EXTRA, 1);
        drain(6);
        // widest frame, then tallest frame
        set_geometry(2047, 2, 15);
        push_pixels(2048);
        drain(1026);
        set_geometry(1, 8191, 0);
        calm = 1'b1;
        push_pixels(4097);
        drain(3);
        calm = 1'b0;

        words_sent = 0;
        while (words_sent < 1500) begin
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(20, 70);
            end else begin
                w = $urandom_range(1, 10);
            end
            h = $urandom_range(1, 6);
            frames = $urandom_range(1, 3);
            calm = ($urandom_range(0, 5) == 0);
            set_geometry(w, h, $urandom_range(0, 15));
            for (int f = 0; f < frames; f++) begin
                for (int p = 0; p < w * h; p++) begin
                    if ($urandom_range(0, 19) == 0) send_word(OP_DRAIN, rand_pixel());
                    if ($urandom_range(0, 199) == 0) wait_drained();
                    send_word(OP_PUSH, rand_pixel());
                end
                if ($urandom_range(0, 3) == 0) send_word(OP_DRAIN, rand_pixel());
            end
            drain(w + 1 + $urandom_range(0, 2));
        end
        calm = 1'b0;

        px_valid <= 1'b0;
        while (chk_waiting != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (chk_errors == 0 && chk_waiting == 0) begin
            $display("tb_weighted_3x3_smoothing_filter_core: clean");
        end else begin
            $display("tb_weighted_3x3_smoothing_filter_core: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
